>>> rtl/core/fre_pkg.sv
// ----------------------------------------------------------------------------
// fre_pkg
// Shared types and codes for the four-register instruction executor.
// ----------------------------------------------------------------------------
package fre_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam int OP_W   = 4;
	localparam int RIDX_W = 2;
	localparam int NREGS  = 4;
	localparam int LINE_W = 7;

	// instruction codes
	localparam logic [OP_W-1:0] OP_READ  = 4'd0;
	localparam logic [OP_W-1:0] OP_PRINT = 4'd1;
	localparam logic [OP_W-1:0] OP_MOV   = 4'd2;
	localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
	localparam logic [OP_W-1:0] OP_SUB   = 4'd4;
	localparam logic [OP_W-1:0] OP_MUL   = 4'd5;
	localparam logic [OP_W-1:0] OP_DIV   = 4'd6;
	localparam logic [OP_W-1:0] OP_JE    = 4'd7;
	localparam logic [OP_W-1:0] OP_JNE   = 4'd8;
	localparam logic [OP_W-1:0] OP_JG    = 4'd9;
	localparam logic [OP_W-1:0] OP_JGE   = 4'd10;
	localparam logic [OP_W-1:0] OP_JL    = 4'd11;
	localparam logic [OP_W-1:0] OP_JLE   = 4'd12;
	localparam logic [OP_W-1:0] OP_JMP   = 4'd13;

	// serial unit operations
	localparam logic [2:0] UOP_ADD = 3'd0;
	localparam logic [2:0] UOP_SUB = 3'd1;
	localparam logic [2:0] UOP_MUL = 3'd2;
	localparam logic [2:0] UOP_DIV = 3'd3;
	localparam logic [2:0] UOP_CMP = 3'd4;

	typedef struct packed {
		logic       start;
		logic [2:0] uop;
	} fre_ctl_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
		logic              eq;
		logic              lt;
	} fre_sts_t;

	function automatic logic [2:0] uop_of(input logic [OP_W-1:0] op);
		logic [2:0] u;
		case (op)
			OP_ADD:  u = UOP_ADD;
			OP_SUB:  u = UOP_SUB;
			OP_MUL:  u = UOP_MUL;
			OP_DIV:  u = UOP_DIV;
			default: u = UOP_CMP;
		endcase
		return u;
	endfunction

endpackage

>>> rtl/core/fre_regfile.sv
// ----------------------------------------------------------------------------
// fre_regfile
// Four 32-bit registers, two read ports and one write port, cleared at reset.
// ----------------------------------------------------------------------------
module fre_regfile import fre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RIDX_W-1:0] ra_idx,
	output logic [DATA_W-1:0] ra_data,
	input  logic [RIDX_W-1:0] rb_idx,
	output logic [DATA_W-1:0] rb_data,
	input  logic              we,
	input  logic [RIDX_W-1:0] w_idx,
	input  logic [DATA_W-1:0] w_data
);

	logic [DATA_W-1:0] regs_q [NREGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (we) begin
			regs_q[w_idx] <= w_data;
		end
	end

	assign ra_data = regs_q[ra_idx];
	assign rb_data = regs_q[rb_idx];

endmodule

>>> rtl/core/fre_serial.sv
// ----------------------------------------------------------------------------
// fre_serial
// Serial arithmetic unit: bit-serial add, subtract and signed compare,
// shift-and-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module fre_serial import fre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fre_ctl_t          ctl,
	input  logic [DATA_W-1:0] x,
	input  logic [DATA_W-1:0] y,
	output fre_sts_t          sts
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       uop_q;

	logic [DATA_W-1:0] opa_q;
	logic [DATA_W-1:0] opb_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] rem_q;
	logic              c_q;
	logic              eq_q;
	logic              lt_q;
	logic              neg_q;

	logic              last;
	logic              a_bit;
	logic              sum_bit;
	logic              carry;
	logic [DATA_W-1:0] mul_sum;
	logic [DATA_W-1:0] div_rem;
	logic [DATA_W:0]   div_diff;

	always_comb begin
		last     = (cnt_q == CNT_W'(DATA_W - 1));
		a_bit    = opa_q[0] ^ (uop_q == UOP_SUB);
		sum_bit  = opb_q[0] ^ a_bit ^ c_q;
		carry    = (opb_q[0] & a_bit) | (opb_q[0] & c_q) | (a_bit & c_q);
		mul_sum  = acc_q + (opa_q[0] ? opb_q : '0);
		// remainder stays below the divisor magnitude, so its top bit is free
		div_rem  = {rem_q[DATA_W-2:0], opa_q[DATA_W-1]};
		div_diff = {1'b0, div_rem} - {1'b0, opb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			uop_q  <= UOP_ADD;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				uop_q  <= ctl.uop;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			rem_q <= '0;
			c_q   <= (ctl.uop == UOP_SUB);
			eq_q  <= 1'b1;
			lt_q  <= 1'b0;
			neg_q <= x[DATA_W-1] ^ y[DATA_W-1];
			if (ctl.uop == UOP_DIV) begin
				// magnitudes in, sign applied on the way out
				opa_q <= x[DATA_W-1] ? -x : x;
				opb_q <= y[DATA_W-1] ? -y : y;
			end else begin
				opa_q <= x;
				opb_q <= y;
			end
		end else if (busy_q) begin
			case (uop_q)
				UOP_ADD, UOP_SUB: begin
					acc_q <= {sum_bit, acc_q[DATA_W-1:1]};
					c_q   <= carry;
					opa_q <= opa_q >> 1;
					opb_q <= opb_q >> 1;
				end
				UOP_CMP: begin
					// lsb first: the highest differing bit decides, the sign bit inverted
					if (opa_q[0] != opb_q[0]) begin
						eq_q <= 1'b0;
						lt_q <= last ? opa_q[0] : opb_q[0];
					end
					opa_q <= opa_q >> 1;
					opb_q <= opb_q >> 1;
				end
				UOP_MUL: begin
					acc_q <= mul_sum;
					opa_q <= opa_q >> 1;
					opb_q <= opb_q << 1;
				end
				UOP_DIV: begin
					if (!div_diff[DATA_W]) begin
						rem_q <= div_diff[DATA_W-1:0];
						acc_q <= {acc_q[DATA_W-2:0], 1'b1};
					end else begin
						rem_q <= div_rem;
						acc_q <= {acc_q[DATA_W-2:0], 1'b0};
					end
					opa_q <= opa_q << 1;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_comb begin
		sts.done   = done_q;
		sts.result = (uop_q == UOP_DIV && neg_q) ? -acc_q : acc_q;
		sts.eq     = eq_q;
		sts.lt     = lt_q;
	end

endmodule

>>> rtl/core/four_register_instruction_executor.sv
// ----------------------------------------------------------------------------
// four_register_instruction_executor
// Runs one decoded instruction per request on a four-entry register file.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | req_type a_is_imm a_reg a_imm b_is_imm b_reg
//           |                      | b_imm target_line read_value
//  out      | out_valid / out_stall| print_valid print_value branch_taken
//           |                      | branch_target div_by_zero
//
// read, print, mov, jmp, unused codes and a zero-divisor div go from
// acceptance straight to the finish state and the result register; add,
// sub, mul, div and the conditional jumps first run the 32 one-bit steps
// of the serial unit.
// One request is in work at a time; the next is taken as soon as the previous
// result has moved into the output register, even if that result is stalled.
// Reset clears the register file and all handshake state.
// ----------------------------------------------------------------------------
module four_register_instruction_executor import fre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   req_type,
	input  logic              a_is_imm,
	input  logic [RIDX_W-1:0] a_reg,
	input  logic signed [DATA_W-1:0] a_imm,
	input  logic              b_is_imm,
	input  logic [RIDX_W-1:0] b_reg,
	input  logic signed [DATA_W-1:0] b_imm,
	input  logic [LINE_W-1:0] target_line,
	input  logic signed [DATA_W-1:0] read_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              print_valid,
	output logic signed [DATA_W-1:0] print_value,
	output logic              branch_taken,
	output logic [LINE_W-1:0] branch_target,
	output logic              div_by_zero
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;

	logic [OP_W-1:0]   op_q;
	logic [RIDX_W-1:0] dst_q;
	logic [LINE_W-1:0] target_q;
	logic              wr_q;
	logic [DATA_W-1:0] wdata_q;
	logic              pv_q;
	logic [DATA_W-1:0] pval_q;
	logic              taken_q;
	logic              dz_q;

	logic              out_valid_q;
	logic              print_valid_q;
	logic [DATA_W-1:0] print_value_q;
	logic              branch_taken_q;
	logic [LINE_W-1:0] branch_target_q;
	logic              div_by_zero_q;

	logic [DATA_W-1:0] ra_data;
	logic [DATA_W-1:0] dst_val;
	logic [DATA_W-1:0] a_val;
	logic [DATA_W-1:0] b_val;
	logic              accept;
	logic              serial;
	logic              dz_now;
	logic              fin_go;
	logic              cond;
	logic              n_wr;
	logic [DATA_W-1:0] n_wdata;
	logic              n_pv;
	logic [DATA_W-1:0] n_pval;
	logic              n_taken;
	logic              n_dz;

	fre_ctl_t ctl;
	fre_sts_t sts;

	fre_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ra_idx  (a_reg),
		.ra_data (ra_data),
		.rb_idx  (b_reg),
		.rb_data (dst_val),
		.we      (fin_go && wr_q),
		.w_idx   (dst_q),
		.w_data  (wdata_q)
	);

	fre_serial u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.x      (a_val),
		.y      ((req_type == OP_ADD || req_type == OP_SUB || req_type == OP_MUL
			|| req_type == OP_DIV) ? dst_val : b_val),
		.sts    (sts)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		a_val   = a_is_imm ? a_imm : ra_data;
		b_val   = b_is_imm ? b_imm : dst_val;
		dz_now  = (req_type == OP_DIV) && (dst_val == '0);
		n_wr    = 1'b0;
		n_wdata = read_value;
		n_pv    = 1'b0;
		n_pval  = '0;
		n_taken = 1'b0;
		n_dz    = 1'b0;
		serial  = 1'b0;
		case (req_type)
			OP_READ: begin
				n_wr = 1'b1;
			end
			OP_PRINT: begin
				n_pv   = 1'b1;
				n_pval = a_val;
			end
			OP_MOV: begin
				n_wr    = 1'b1;
				n_wdata = a_val;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
				serial = 1'b1;
			end
			OP_DIV: begin
				serial = !dz_now;
				n_dz   = dz_now;
			end
			OP_JMP: begin
				n_taken = 1'b1;
			end
			default: begin
				n_wr = 1'b0;
			end
		endcase
		ctl.start = accept && serial;
		ctl.uop   = uop_of(req_type);
	end

	always_comb begin
		case (op_q)
			OP_JE:   cond = sts.eq;
			OP_JNE:  cond = !sts.eq;
			OP_JG:   cond = !sts.lt && !sts.eq;
			OP_JGE:  cond = !sts.lt;
			OP_JL:   cond = sts.lt;
			OP_JLE:  cond = sts.lt || sts.eq;
			default: cond = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= serial ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					if (sts.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req_type;
			dst_q    <= b_reg;
			target_q <= target_line;
			wr_q     <= n_wr;
			wdata_q  <= n_wdata;
			pv_q     <= n_pv;
			pval_q   <= n_pval;
			taken_q  <= n_taken;
			dz_q     <= n_dz;
		end else if (state_q == ST_RUN && sts.done) begin
			// compares report a branch, everything else writes back
			if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL || op_q == OP_DIV) begin
				wr_q    <= 1'b1;
				wdata_q <= sts.result;
			end else begin
				taken_q <= cond;
			end
		end
		if (fin_go) begin
			print_valid_q   <= pv_q;
			print_value_q   <= pval_q;
			branch_taken_q  <= taken_q;
			branch_target_q <= taken_q ? target_q : '0;
			div_by_zero_q   <= dz_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign print_valid   = print_valid_q;
	assign print_value   = print_value_q;
	assign branch_taken  = branch_taken_q;
	assign branch_target = branch_target_q;
	assign div_by_zero   = div_by_zero_q;

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == ST_RUN)
		else $error("serial unit finished outside a running request");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> state_q == ST_RUN)
		else $error("serial unit started without entering run state");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(div_by_zero && (print_valid || branch_taken)))
		else $error("result carries more than one kind of outcome");

	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !branch_taken) |-> branch_target == '0)
		else $error("branch target set on a branch not taken");

endmodule
